@@ rtl/elt_pkg.sv @@
// Shared types, register indexes and character constants of the escaped-list tokenizer.
package elt_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ESCAPE_CHAR    = 3'd0;
    localparam logic [2:0] CFG_SEPARATOR_CHAR = 3'd1;
    localparam logic [2:0] CFG_QUOTE_CHAR     = 3'd2;
    localparam logic [2:0] CFG_COMMENT_START  = 3'd3;
    localparam logic [2:0] CFG_COMMENT_END    = 3'd4;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 9;

    // Reset values of the registers.
    localparam logic [8:0] RST_ESCAPE_CHAR    = 9'd92;
    localparam logic [8:0] RST_SEPARATOR_CHAR = 9'd44;
    localparam logic [8:0] RST_QUOTE_CHAR     = 9'd34;
    localparam logic [7:0] RST_COMMENT_START  = 8'd35;
    localparam logic [7:0] RST_COMMENT_END    = 8'd10;

    // The letter that turns an escape into a newline, and the newline itself.
    localparam logic [7:0] CHAR_N       = 8'h6e;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

    // Depth of the queue between the classifier and the tokenizer core.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_BAD_ESCAPE  = 2'd1,
        ERR_END_ESCAPE  = 2'd2
    } elt_err_t;

    // One classified input word: the byte plus its matches against the registers.
    typedef struct packed {
        logic       is_end;
        logic       is_cmt_end;
        logic       is_n;
        logic       is_esc;
        logic       is_sep;
        logic       is_qchar;
        logic       is_cmt_start;
        logic [7:0] ch;
    } elt_class_t;

    // Tokenizer state carried from word to word.
    typedef struct packed {
        logic in_quote;
        logic in_comment;
        logic escape_pending;
        logic token_open;
        logic failed;
    } elt_state_t;

    // One result word.
    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_char;
        logic       token_end;
        elt_err_t   error_code;
    } elt_result_t;

endpackage

@@ rtl/elt_front.sv @@
// Front end: configuration registers, input acceptance and character classification.
module elt_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,
    input  logic                          s_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [elt_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [elt_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                          q_push,
    input  logic                          q_ready,
    output elt_pkg::elt_class_t           q_data
);

    logic [8:0] escape_reg;
    logic [8:0] separator_reg;
    logic [8:0] quote_reg;
    logic [7:0] cmt_start_reg;
    logic [7:0] cmt_end_reg;

    logic                stage_valid_reg;
    logic                stage_valid_next;
    elt_pkg::elt_class_t stage_reg;
    elt_pkg::elt_class_t stage_next;
    logic                accept;
    logic [8:0]          ch9;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_reg    <= elt_pkg::RST_ESCAPE_CHAR;
            separator_reg <= elt_pkg::RST_SEPARATOR_CHAR;
            quote_reg     <= elt_pkg::RST_QUOTE_CHAR;
            cmt_start_reg <= elt_pkg::RST_COMMENT_START;
            cmt_end_reg   <= elt_pkg::RST_COMMENT_END;
        end else if (cfg_valid) begin
            case (cfg_addr)
                elt_pkg::CFG_ESCAPE_CHAR:    escape_reg    <= cfg_data;
                elt_pkg::CFG_SEPARATOR_CHAR: separator_reg <= cfg_data;
                elt_pkg::CFG_QUOTE_CHAR:     quote_reg     <= cfg_data;
                elt_pkg::CFG_COMMENT_START:  cmt_start_reg <= cfg_data[7:0];
                elt_pkg::CFG_COMMENT_END:    cmt_end_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // The stage can take a word when it is empty or its word moves on this cycle.
    assign s_tready = !stage_valid_reg || q_ready;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = stage_valid_reg && q_ready;
    assign q_data   = stage_reg;
    assign ch9      = {1'b0, s_tdata};

    always_comb begin
        stage_next              = stage_reg;
        stage_next.is_end       = s_tuser;
        stage_next.ch           = s_tdata;
        stage_next.is_cmt_end   = (s_tdata == cmt_end_reg);
        stage_next.is_n         = (s_tdata == elt_pkg::CHAR_N);
        stage_next.is_esc       = (ch9 == escape_reg);
        stage_next.is_sep       = (ch9 == separator_reg);
        stage_next.is_qchar     = (ch9 == quote_reg);
        stage_next.is_cmt_start = (s_tdata == cmt_start_reg);
        if (accept) begin
            stage_valid_next = 1'b1;
        end else if (q_push) begin
            stage_valid_next = 1'b0;
        end else begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stage_reg <= stage_next;
        end
    end

endmodule

@@ rtl/elt_queue.sv @@
// Short queue of classified words between the front end and the tokenizer core.
module elt_queue #(
    parameter int Depth = elt_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    output logic                in_ready,
    input  elt_pkg::elt_class_t in_data,
    output logic                out_valid,
    input  logic                pop,
    output elt_pkg::elt_class_t out_data
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    elt_pkg::elt_class_t  mem_reg [Depth];
    logic [PtrW-1:0]      wr_ptr_reg;
    logic [PtrW-1:0]      wr_ptr_next;
    logic [PtrW-1:0]      rd_ptr_reg;
    logic [PtrW-1:0]      rd_ptr_next;
    logic [CntW-1:0]      count_reg;
    logic [CntW-1:0]      count_next;
    logic                 do_push;
    logic                 do_pop;

    assign in_ready  = (count_reg != CntW'(Depth));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && in_ready;
    assign do_pop    = pop && out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ rtl/elt_back.sv @@
// Tokenizer core: applies the quote, escape and comment rules and holds the result register.
module elt_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_pop,
    input  elt_pkg::elt_class_t q_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output elt_pkg::elt_result_t m_result
);

    elt_pkg::elt_state_t  st_reg;
    elt_pkg::elt_state_t  st_next;
    elt_pkg::elt_state_t  st_work;
    elt_pkg::elt_result_t res_reg;
    elt_pkg::elt_result_t res_work;
    logic                 valid_reg;
    logic                 valid_next;

    // A new word is taken whenever the result register is empty or being drained.
    assign q_pop    = q_valid && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_result = res_reg;

    always_comb begin
        st_work             = st_reg;
        res_work.char_valid = 1'b0;
        res_work.out_char   = '0;
        res_work.token_end  = 1'b0;
        res_work.error_code = elt_pkg::ERR_NONE;

        if (q_data.is_end) begin
            if (!st_reg.failed) begin
                if (st_reg.escape_pending) begin
                    res_work.error_code = elt_pkg::ERR_END_ESCAPE;
                end else if (!st_reg.in_comment && st_reg.token_open) begin
                    res_work.token_end = 1'b1;
                end
            end
            st_work = '0;
        end else if (st_reg.failed) begin
            // Silent until the end word.
        end else if (st_reg.in_comment) begin
            if (q_data.is_cmt_end) begin
                st_work.in_comment = 1'b0;
            end
        end else if (st_reg.escape_pending) begin
            st_work.escape_pending = 1'b0;
            if (q_data.is_n) begin
                res_work.char_valid = 1'b1;
                res_work.out_char   = elt_pkg::CHAR_NEWLINE;
            end else if (q_data.is_qchar || q_data.is_sep || q_data.is_esc) begin
                res_work.char_valid = 1'b1;
                res_work.out_char   = q_data.ch;
            end else begin
                res_work.error_code = elt_pkg::ERR_BAD_ESCAPE;
                st_work.failed      = 1'b1;
            end
        end else if (!st_reg.in_quote && q_data.is_cmt_start) begin
            res_work.token_end = 1'b1;
            st_work.in_comment = 1'b1;
            st_work.token_open = 1'b0;
        end else if (q_data.is_esc) begin
            st_work.escape_pending = 1'b1;
            st_work.token_open     = 1'b1;
        end else if (q_data.is_sep) begin
            st_work.token_open = 1'b1;
            if (!st_reg.in_quote) begin
                res_work.token_end = 1'b1;
            end else begin
                res_work.char_valid = 1'b1;
                res_work.out_char   = q_data.ch;
            end
        end else if (q_data.is_qchar) begin
            st_work.in_quote   = !st_reg.in_quote;
            st_work.token_open = 1'b1;
        end else begin
            res_work.char_valid = 1'b1;
            res_work.out_char   = q_data.ch;
            st_work.token_open  = 1'b1;
        end

        st_next = q_pop ? st_work : st_reg;
        if (q_pop) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= '0;
            valid_reg <= 1'b0;
        end else begin
            st_reg    <= st_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            res_reg <= res_work;
        end
    end

endmodule

@@ rtl/escaped_list_tokenizer_with_comments.sv @@
// Top level of the streaming escaped-list tokenizer with comment skipping.
//
// This block splits a byte stream into CSV-style tokens. Each input word is either one
// character (s_tuser low) or the end-of-input mark (s_tuser high), and each input word
// gives exactly one output word: a token character (m_tuser bit 0 set, byte on m_tdata),
// a token end (m_tlast), an error code (m_tuser bits 2:1), or an all-zero word when there
// is nothing to report. Outside quotes the comment-start byte ends the current token and
// everything up to and including the comment-end byte is dropped. An escape byte takes the
// next byte: 'n' becomes a newline, and the quote, separator or escape byte passes through
// as a plain character; anything else reports an unknown escape, after which the block
// returns empty words until the end mark. The end mark closes a pending token (so a
// trailing separator gives one empty token), reports an error when it follows an escape,
// and returns all tokenizer state to its reset value. The block takes one word per clock
// cycle sustained while the output is not stalled; a word's result passes through the
// classifier register, the queue and the result register on its way to the output. The
// queue between the classifier and the tokenizer core lets the input keep flowing while
// the output stalls briefly. Configuration registers (escape, separator and quote codes,
// where 256 means unused, and the comment start and end bytes) may be written only while
// the block holds no words in flight.
module escaped_list_tokenizer_with_comments #(
    parameter int QueueDepth = elt_pkg::QUEUE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] in_char
    input  logic                           s_tuser,   // [0] func: 1 marks end of input
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [7:0] out_char
    output logic                           m_tlast,   // token_end
    output logic [2:0]                     m_tuser,   // [0] char_valid, [2:1] error_code
    // Configuration writes.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [elt_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [elt_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic                 q_push;
    logic                 q_in_ready;
    elt_pkg::elt_class_t  q_in_data;
    logic                 q_out_valid;
    logic                 q_pop;
    elt_pkg::elt_class_t  q_out_data;
    elt_pkg::elt_result_t result;

    // Classifier: compares each byte against the registers once, so the core sees match
    // flags alongside the byte itself.
    elt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .q_push    (q_push),
        .q_ready   (q_in_ready),
        .q_data    (q_in_data)
    );

    elt_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .pop       (q_pop),
        .out_data  (q_out_data)
    );

    // Core: quote, escape and comment state, plus the output register.
    elt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_out_valid),
        .q_pop    (q_pop),
        .q_data   (q_out_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (result)
    );

    assign m_tdata = result.out_char;
    assign m_tlast = result.token_end;
    assign m_tuser = {result.error_code, result.char_valid};

endmodule

@@ rtl/elt_checker.sv @@
// Port-level checks of the tokenizer output, bound to the top level.
module elt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [2:0] m_tuser
);

    // A word that carries no character carries a zero byte.
    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'd0))
        else $error("output byte not zero without a character");

    // A character word is never also a token end or an error.
    a_char_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (!m_tlast && m_tuser[2:1] == elt_pkg::ERR_NONE))
        else $error("character word also carries an end or an error");

    // An error word never ends a token.
    a_err_no_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2:1] != elt_pkg::ERR_NONE) |-> !m_tlast)
        else $error("error word also ends a token");

    // A stalled result word stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
        else $error("stalled result word changed");

endmodule

bind escaped_list_tokenizer_with_comments elt_checker u_elt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

@@ bench/testbench.sv @@
// Self-checking testbench for the streaming escaped-list tokenizer with comment skipping.
`timescale 1ns / 1ps

module testbench;

    // Values of the input word's func field, carried on s_tuser.
    localparam logic FUNC_CHAR = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    // Characters of the default register setting, used by the directed rows.
    localparam logic [7:0] ESC_B   = elt_pkg::RST_ESCAPE_CHAR[7:0];
    localparam logic [7:0] SEP_B   = elt_pkg::RST_SEPARATOR_CHAR[7:0];
    localparam logic [7:0] QUOTE_B = elt_pkg::RST_QUOTE_CHAR[7:0];
    localparam logic [7:0] CMT_B   = elt_pkg::RST_COMMENT_START;
    localparam logic [7:0] NL_B    = elt_pkg::RST_COMMENT_END;

    // Receiver behaviors: always ready, light stalls, heavy stalls, long stall runs.
    localparam logic [1:0] RX_OPEN  = 2'd0;
    localparam logic [1:0] RX_LIGHT = 2'd1;
    localparam logic [1:0] RX_HEAVY = 2'd2;
    localparam logic [1:0] RX_LONG  = 2'd3;

    localparam int PHASE_COUNT = 6;
    localparam int PHASE_ITEMS = 80;

    // One row of the directed table. When pinned is set, want is the typed-in result;
    // otherwise the result comes from the predictor.
    typedef struct {
        logic                 is_end;
        logic [7:0]           ch;
        logic                 pinned;
        elt_pkg::elt_result_t want;
    } step_row_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata = 8'd0;
    logic                           s_tuser = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [7:0]                     m_tdata;
    logic                           m_tlast;
    logic [2:0]                     m_tuser;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [elt_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [elt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Our own copy of the registers and of the tokenizer state.
    logic [8:0]          esc_code;
    logic [8:0]          sep_code;
    logic [8:0]          quote_code;
    logic [7:0]          cmt_open;
    logic [7:0]          cmt_close;
    elt_pkg::elt_state_t tok_state;

    // Results still owed by the block, oldest first.
    elt_pkg::elt_result_t token_words_due[$];
    step_row_t            directed_rows[$];

    int mismatch_count = 0;
    int live_items = 0;
    int burst_left = 0;
    int stall_run = 0;
    logic [1:0] stall_mode = RX_OPEN;

    escaped_list_tokenizer_with_comments dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Hard stop in case the block hangs or never delivers an owed word.
    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
    endtask

    function automatic elt_pkg::elt_result_t mk_result(input logic cv, input logic [7:0] oc,
                                                       input logic te,
                                                       input elt_pkg::elt_err_t err);
        elt_pkg::elt_result_t r;
        r.char_valid = cv;
        r.out_char   = oc;
        r.token_end  = te;
        r.error_code = err;
        return r;
    endfunction

    function automatic step_row_t mk_row(input logic is_end, input logic [7:0] ch,
                                         input logic pinned,
                                         input elt_pkg::elt_result_t want);
        step_row_t row;
        row.is_end = is_end;
        row.ch     = ch;
        row.pinned = pinned;
        row.want   = want;
        return row;
    endfunction

    // Appends one row to the directed table.
    function automatic void add_row(input step_row_t row);
        directed_rows = {directed_rows, row};
    endfunction

    // Mirror of a register write; indexes past the last register change nothing.
    function automatic void apply_config(input logic [elt_pkg::CFG_ADDR_W-1:0] addr,
                                         input logic [elt_pkg::CFG_DATA_W-1:0] data);
        case (addr)
            elt_pkg::CFG_ESCAPE_CHAR:    esc_code = data;
            elt_pkg::CFG_SEPARATOR_CHAR: sep_code = data;
            elt_pkg::CFG_QUOTE_CHAR:     quote_code = data;
            elt_pkg::CFG_COMMENT_START:  cmt_open = data[7:0];
            elt_pkg::CFG_COMMENT_END:    cmt_close = data[7:0];
            default: ;
        endcase
    endfunction

    // Advances the tokenizer state by one input word and returns the word it must produce.
    // A 9-bit code of 256 is compared against a zero-extended byte, so it never matches.
    function automatic elt_pkg::elt_result_t tokenize_predict(input logic is_end,
                                                              input logic [7:0] ch);
        elt_pkg::elt_result_t r;
        logic [8:0]           c9;
        r  = mk_result(1'b0, 8'd0, 1'b0, elt_pkg::ERR_NONE);
        c9 = {1'b0, ch};
        if (is_end) begin
            // The end mark closes a pending token or reports a dangling escape, then
            // everything returns to its reset value, even after an error.
            if (!tok_state.failed) begin
                if (tok_state.escape_pending) begin
                    r.error_code = elt_pkg::ERR_END_ESCAPE;
                end else if (!tok_state.in_comment && tok_state.token_open) begin
                    r.token_end = 1'b1;
                end
            end
            tok_state = '0;
        end else if (tok_state.failed) begin
            // Silent until the end mark.
        end else if (tok_state.in_comment) begin
            if (ch == cmt_close) begin
                tok_state.in_comment = 1'b0;
            end
        end else if (tok_state.escape_pending) begin
            // The escape takes the next byte whatever it is, a comment start included.
            tok_state.escape_pending = 1'b0;
            if (ch == elt_pkg::CHAR_N) begin
                r.char_valid = 1'b1;
                r.out_char   = elt_pkg::CHAR_NEWLINE;
            end else if (c9 == quote_code || c9 == sep_code || c9 == esc_code) begin
                r.char_valid = 1'b1;
                r.out_char   = ch;
            end else begin
                r.error_code     = elt_pkg::ERR_BAD_ESCAPE;
                tok_state.failed = 1'b1;
            end
        end else if (!tok_state.in_quote && ch == cmt_open) begin
            r.token_end          = 1'b1;
            tok_state.in_comment = 1'b1;
            tok_state.token_open = 1'b0;
            tok_state.in_quote   = 1'b0;
        end else if (c9 == esc_code) begin
            tok_state.escape_pending = 1'b1;
            tok_state.token_open     = 1'b1;
        end else if (c9 == sep_code) begin
            if (!tok_state.in_quote) begin
                r.token_end = 1'b1;
            end else begin
                r.char_valid = 1'b1;
                r.out_char   = ch;
            end
            tok_state.token_open = 1'b1;
        end else if (c9 == quote_code) begin
            tok_state.in_quote   = !tok_state.in_quote;
            tok_state.token_open = 1'b1;
        end else begin
            r.char_valid         = 1'b1;
            r.out_char           = ch;
            tok_state.token_open = 1'b1;
        end
        return r;
    endfunction

    // Offers one input word and waits for the block to take it. The sender works in bursts:
    // when a burst runs out, valid drops for a random gap before the next burst begins.
    // A gap of zero keeps valid high, so long stretches of back-to-back words also occur.
    task automatic send_item(input logic is_end, input logic [7:0] ch,
                             input logic pinned, input elt_pkg::elt_result_t want);
        int                   gap;
        elt_pkg::elt_result_t due;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= is_end;
        s_tdata  <= ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // The word was taken at this edge. Words the block merely skips do not count.
        if (is_end || !(tok_state.failed || tok_state.in_comment)) begin
            live_items++;
        end
        due = tokenize_predict(is_end, ch);
        token_words_due = {token_words_due, (pinned ? want : due)};
    endtask

    task automatic send_plain(input logic is_end, input logic [7:0] ch);
        send_item(is_end, ch, 1'b0, mk_result(1'b0, 8'd0, 1'b0, elt_pkg::ERR_NONE));
    endtask

    // Writes one register. Valid stays high so that the next write can follow at once;
    // the caller lowers it after the last write of a group.
    task automatic cfg_write(input logic [elt_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [elt_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_config(addr, data);
    endtask

    task automatic load_config(input logic [8:0] esc, input logic [8:0] sep,
                               input logic [8:0] quote, input logic [8:0] copen,
                               input logic [8:0] cclose);
        cfg_write(elt_pkg::CFG_ESCAPE_CHAR, esc);
        cfg_write(elt_pkg::CFG_SEPARATOR_CHAR, sep);
        cfg_write(elt_pkg::CFG_QUOTE_CHAR, quote);
        cfg_write(elt_pkg::CFG_COMMENT_START, copen);
        cfg_write(elt_pkg::CFG_COMMENT_END, cclose);
    endtask

    // Waits until every owed word has come back, so that nothing is in flight.
    task automatic wait_drained();
        while (token_words_due.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [8:0] pick_code();
        return ($urandom_range(0, 7) == 0) ? 9'd256 : 9'($urandom_range(0, 255));
    endfunction

    // One record with random content: plain bytes, separators, quotes, escapes
    // followed mostly by legal bytes, and comments that mostly close. Now and then an escape
    // is left dangling or followed by a byte it cannot take, and a few records never end.
    task automatic send_record();
        int len;
        int k;
        int roll;
        int body;
        len = $urandom_range(1, 16);
        for (k = 0; k < len; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 14) begin
                send_plain(FUNC_CHAR, esc_code[7:0]);
                if (k == len - 1 && $urandom_range(0, 2) == 0) begin
                    continue;
                end
                case ($urandom_range(0, 11))
                    0, 1, 2: send_plain(FUNC_CHAR, elt_pkg::CHAR_N);
                    3, 4:    send_plain(FUNC_CHAR, quote_code[7:0]);
                    5, 6:    send_plain(FUNC_CHAR, sep_code[7:0]);
                    7, 8, 9: send_plain(FUNC_CHAR, esc_code[7:0]);
                    10:      send_plain(FUNC_CHAR, cmt_open);
                    default: send_plain(FUNC_CHAR, 8'($urandom_range(0, 255)));
                endcase
            end else if (roll < 30) begin
                send_plain(FUNC_CHAR, sep_code[7:0]);
            end else if (roll < 40) begin
                send_plain(FUNC_CHAR, quote_code[7:0]);
            end else if (roll < 47) begin
                send_plain(FUNC_CHAR, cmt_open);
                for (body = $urandom_range(0, 4); body > 0; body--) begin
                    send_plain(FUNC_CHAR, 8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 4) != 0) begin
                    send_plain(FUNC_CHAR, cmt_close);
                end
            end else if (roll < 52) begin
                send_plain(FUNC_CHAR,
                           ($urandom_range(0, 1) == 0) ? cmt_close : elt_pkg::CHAR_N);
            end else begin
                send_plain(FUNC_CHAR, 8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 11) != 0) begin
            send_plain(FUNC_END, 8'($urandom_range(0, 255)));
        end
    endtask

    // The receiver switches between behaviors after runs of random length, so stalls land on
    // every phase of the pipeline and there are also stretches with no stall at all.
    always @(posedge aclk) begin
        if (stall_run == 0) begin
            stall_mode <= 2'($urandom_range(0, 3));
            stall_run  <= $urandom_range(20, 120);
        end else begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            RX_OPEN:  m_tready <= 1'b1;
            RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: m_tready <= ($urandom_range(0, 2) == 0);
            default:  m_tready <= (stall_run[3:0] < 4'd3);
        endcase
    end

    // Every result word taken from the block is matched against the oldest owed word.
    // m_tuser carries char_valid in bit 0 and the error code in bits 2:1.
    always @(posedge aclk) begin : result_check
        elt_pkg::elt_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (token_words_due.size() == 0) begin
                flag_mismatch($sformatf("result word with nothing owed: data %h last %b user %b",
                                        m_tdata, m_tlast, m_tuser));
            end else begin
                want = token_words_due.pop_front();
                if (m_tuser[0] !== want.char_valid) begin
                    flag_mismatch($sformatf("char_valid %b, wanted %b",
                                            m_tuser[0], want.char_valid));
                end
                if (m_tdata !== want.out_char) begin
                    flag_mismatch($sformatf("out_char %h, wanted %h", m_tdata, want.out_char));
                end
                if (m_tlast !== want.token_end) begin
                    flag_mismatch($sformatf("token_end %b, wanted %b", m_tlast, want.token_end));
                end
                if (m_tuser[2:1] !== want.error_code) begin
                    flag_mismatch($sformatf("error_code %0d, wanted %0d",
                                            m_tuser[2:1], want.error_code));
                end
            end
        end
    end

    initial begin : stimulus
        int ph;
        int goal;
        step_row_t row;
        elt_pkg::elt_result_t quiet;

        esc_code   = elt_pkg::RST_ESCAPE_CHAR;
        sep_code   = elt_pkg::RST_SEPARATOR_CHAR;
        quote_code = elt_pkg::RST_QUOTE_CHAR;
        cmt_open   = elt_pkg::RST_COMMENT_START;
        cmt_close  = elt_pkg::RST_COMMENT_END;
        tok_state  = '0;
        quiet      = mk_result(1'b0, 8'd0, 1'b0, elt_pkg::ERR_NONE);

        // Directed words under the reset register values. Pinned rows carry results that
        // follow directly from the rules: an empty input, a trailing separator, the byte
        // extremes, the escaped newline and the error cases.
        add_row(mk_row(FUNC_END, 8'h00, 1'b1, quiet));
        add_row(mk_row(FUNC_CHAR, "a", 1'b0, quiet));
        add_row(mk_row(FUNC_CHAR, SEP_B, 1'b0, quiet));
        add_row(mk_row(FUNC_END, 8'hff, 1'b1,
                       mk_result(1'b0, 8'd0, 1'b1, elt_pkg::ERR_NONE)));
        // A quoted separator is an ordinary character.
        add_row(mk_row(FUNC_CHAR, QUOTE_B, 1'b0, quiet));
        add_row(mk_row(FUNC_CHAR, SEP_B, 1'b0, quiet));
        add_row(mk_row(FUNC_CHAR, QUOTE_B, 1'b0, quiet));
        // Escaped newline, escaped quote.
        add_row(mk_row(FUNC_CHAR, ESC_B, 1'b0, quiet));
        add_row(mk_row(FUNC_CHAR, elt_pkg::CHAR_N, 1'b1,
                       mk_result(1'b1, elt_pkg::CHAR_NEWLINE, 1'b0, elt_pkg::ERR_NONE)));
        add_row(mk_row(FUNC_CHAR, ESC_B, 1'b0, quiet));
        add_row(mk_row(FUNC_CHAR, QUOTE_B, 1'b0, quiet));
        // A comment ends the token and swallows everything through its closing byte.
        add_row(mk_row(FUNC_CHAR, CMT_B, 1'b0, quiet));
        add_row(mk_row(FUNC_CHAR, "x", 1'b0, quiet));
        add_row(mk_row(FUNC_CHAR, NL_B, 1'b0, quiet));
        add_row(mk_row(FUNC_CHAR, 8'hff, 1'b1,
                       mk_result(1'b1, 8'hff, 1'b0, elt_pkg::ERR_NONE)));
        add_row(mk_row(FUNC_CHAR, 8'h00, 1'b1,
                       mk_result(1'b1, 8'h00, 1'b0, elt_pkg::ERR_NONE)));
        // The escape takes a comment start, which it cannot pass, and the block falls silent.
        add_row(mk_row(FUNC_CHAR, ESC_B, 1'b0, quiet));
        add_row(mk_row(FUNC_CHAR, CMT_B, 1'b1,
                       mk_result(1'b0, 8'd0, 1'b0, elt_pkg::ERR_BAD_ESCAPE)));
        add_row(mk_row(FUNC_CHAR, "q", 1'b1, quiet));
        add_row(mk_row(FUNC_END, 8'h00, 1'b1, quiet));
        // Input ending right after an escape.
        add_row(mk_row(FUNC_CHAR, ESC_B, 1'b0, quiet));
        add_row(mk_row(FUNC_END, 8'h00, 1'b1,
                       mk_result(1'b0, 8'd0, 1'b0, elt_pkg::ERR_END_ESCAPE)));
        // Input ending inside a comment ends no token.
        add_row(mk_row(FUNC_CHAR, "b", 1'b0, quiet));
        add_row(mk_row(FUNC_CHAR, CMT_B, 1'b0, quiet));
        add_row(mk_row(FUNC_END, 8'h00, 1'b1, quiet));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_item(row.is_end, row.ch, row.pinned, row.want);
        end

        // Random phases, each under its own register setting. Registers change only once
        // every owed word has come back. Each phase also writes one index past the last
        // register, which the block must ignore.
        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            s_tvalid <= 1'b0;
            wait_drained();
            case (ph)
                0: load_config(elt_pkg::RST_ESCAPE_CHAR, elt_pkg::RST_SEPARATOR_CHAR,
                               elt_pkg::RST_QUOTE_CHAR,
                               {1'b0, elt_pkg::RST_COMMENT_START},
                               {1'b0, elt_pkg::RST_COMMENT_END});
                // No escape, separator or quote at all; comment bytes at the extremes.
                1: load_config(9'd256, 9'd256, 9'd256, 9'd0, 9'd255);
                2: load_config(9'd255, 9'd0, 9'd128, 9'd255, 9'd0);
                // Every role on the same byte, so precedence alone decides.
                3: load_config(9'h061, 9'h061, 9'h061, 9'h061, 9'h061);
                default: load_config(pick_code(), pick_code(), pick_code(),
                                     9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
            endcase
            cfg_write(elt_pkg::CFG_COMMENT_END + 3'd1 + 3'(ph % 3),
                      9'($urandom_range(0, 511)));
            cfg_valid <= 1'b0;
            goal = live_items + PHASE_ITEMS;
            while (live_items < goal) send_record();
        end

        s_tvalid <= 1'b0;
        wait_drained();
        // Keep watching the output in case the block sends a word nobody asked for.
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ escaped_list_tokenizer_with_comments.f @@
rtl/elt_pkg.sv
rtl/elt_front.sv
rtl/elt_queue.sv
rtl/elt_back.sv
rtl/escaped_list_tokenizer_with_comments.sv
rtl/elt_checker.sv
bench/testbench.sv
